// ===== hw/rtl/zener_voltage_rms_smoother_unit_defines.svh =====
// -----------------------------------------------------------------------------
// zener voltage rms smoother assertion macros
// shared property forms for the checks at the end of the top level
// -----------------------------------------------------------------------------
`ifndef ZENER_VOLTAGE_RMS_SMOOTHER_UNIT_DEFINES_SVH
`define ZENER_VOLTAGE_RMS_SMOOTHER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ZVRS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("zvrs check failed");

// next-cycle implication, sampled on clk, off during reset
`define ZVRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("zvrs check failed");

`endif

// ===== hw/rtl/zvrs_pkg.sv =====
// -----------------------------------------------------------------------------
// zvrs_pkg
// widths, register codes, command types and helpers of the rms smoother
// -----------------------------------------------------------------------------
package zvrs_pkg;

	localparam int ADC_W   = 13;
	localparam int MV_W    = 16;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 2;
	localparam int MS_W    = 48;
	localparam int ACC_W   = 64;
	localparam int PROD_W  = 33;
	localparam int SQ_W    = 32;
	localparam int SCALE_FRAC_BITS = 12;

	localparam int MAC_STEPS  = 5;
	localparam int SQRT_STEPS = 16;
	localparam int CNT_W      = 4;

	// register indexes
	localparam logic [IDX_W-1:0] REG_CLAMP = 2'd0;
	localparam logic [IDX_W-1:0] REG_SCALE = 2'd1;
	localparam logic [IDX_W-1:0] REG_MINZ  = 2'd2;
	localparam logic [IDX_W-1:0] REG_ALPHA = 2'd3;

	localparam logic [ADC_W-1:0] CLAMP_RST = 13'd4950;
	localparam logic [CFG_W-1:0] SCALE_RST = 16'd22714;
	localparam logic [CFG_W-1:0] MINZ_RST  = 16'd500;
	localparam logic [CFG_W-1:0] ALPHA_RST = 16'd3277;

	typedef struct packed {
		logic [ADC_W-1:0] clamp_mv;
		logic [CFG_W-1:0] scale_q12;
		logic [CFG_W-1:0] min_zener_mv;
		logic [CFG_W-1:0] alpha_q16;
	} cfg_t;

	// operand pairs of the shared multiplier
	typedef enum logic [2:0] {
		MUL_SCALE  = 3'd0,
		MUL_SQUARE = 3'd1,
		MUL_MS0    = 3'd2,
		MUL_MS1    = 3'd3,
		MUL_MS2    = 3'd4,
		MUL_SQ0    = 3'd5,
		MUL_SQ1    = 3'd6
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     scale_fin;
		logic     flag;
		logic     sq_fin;
		logic     acc_add;
		logic     ms_upd;
		logic     sqrt_step;
		logic     publish;
	} dp_cmd_t;

	typedef struct packed {
		logic below;
	} dp_sts_t;

	// partial product order of the mean square update
	function automatic mul_sel_t mac_sel(input logic [2:0] k);
		mul_sel_t s;
		unique case (k)
			3'd0:    s = MUL_MS0;
			3'd1:    s = MUL_MS1;
			3'd2:    s = MUL_MS2;
			3'd3:    s = MUL_SQ0;
			default: s = MUL_SQ1;
		endcase
		return s;
	endfunction

endpackage

// ===== hw/rtl/zvrs_in_if.sv =====
// -----------------------------------------------------------------------------
// zvrs_in_if
// input channel: one adc reading per item
// -----------------------------------------------------------------------------
interface zvrs_in_if;
	import zvrs_pkg::*;

	logic             valid;
	logic             ready;
	logic [ADC_W-1:0] adc_mv;

	modport source (output valid, output adc_mv, input ready);
	modport sink (input valid, input adc_mv, output ready);
endinterface

// ===== hw/rtl/zvrs_out_if.sv =====
// -----------------------------------------------------------------------------
// zvrs_out_if
// output channel: smoothed rms voltage and not-a-zener flag
// -----------------------------------------------------------------------------
interface zvrs_out_if;
	import zvrs_pkg::*;

	logic            valid;
	logic            ready;
	logic [MV_W-1:0] rms_mv;
	logic            not_zener;

	modport source (output valid, output rms_mv, output not_zener, input ready);
	modport sink (input valid, input rms_mv, input not_zener, output ready);
endinterface

// ===== hw/rtl/zvrs_cfg_if.sv =====
// -----------------------------------------------------------------------------
// zvrs_cfg_if
// configuration write channel: register index and write data
// -----------------------------------------------------------------------------
interface zvrs_cfg_if;
	import zvrs_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] index;
	logic [CFG_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/zvrs_cfg_regs.sv =====
// -----------------------------------------------------------------------------
// zvrs_cfg_regs
// configuration register file, always ready for a write
// -----------------------------------------------------------------------------
module zvrs_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	zvrs_cfg_if.sink        cfg,
	output zvrs_pkg::cfg_t  regs
);
	import zvrs_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.clamp_mv     <= CLAMP_RST;
			regs_q.scale_q12    <= SCALE_RST;
			regs_q.min_zener_mv <= MINZ_RST;
			regs_q.alpha_q16    <= ALPHA_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CLAMP: regs_q.clamp_mv     <= cfg.data[ADC_W-1:0];
				REG_SCALE: regs_q.scale_q12    <= cfg.data;
				REG_MINZ:  regs_q.min_zener_mv <= cfg.data;
				REG_ALPHA: regs_q.alpha_q16    <= cfg.data;
				default:   regs_q <= regs_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/zvrs_ctrl.sv =====
// -----------------------------------------------------------------------------
// zvrs_ctrl
// sequencer: scale, threshold, square, mean square update, bitwise sqrt
// -----------------------------------------------------------------------------
module zvrs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output zvrs_pkg::dp_cmd_t cmd,
	input  zvrs_pkg::dp_sts_t sts
);
	import zvrs_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE    = 11'b000_0000_0001,
		ST_SCL_MUL = 11'b000_0000_0010,
		ST_SCL_FIN = 11'b000_0000_0100,
		ST_CMP     = 11'b000_0000_1000,
		ST_SQ_MUL  = 11'b000_0001_0000,
		ST_SQ_FIN  = 11'b000_0010_0000,
		ST_MAC_MUL = 11'b000_0100_0000,
		ST_MAC_ADD = 11'b000_1000_0000,
		ST_MS_UPD  = 11'b001_0000_0000,
		ST_SQRT    = 11'b010_0000_0000,
		ST_DONE    = 11'b100_0000_0000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;
	logic             out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCL_MUL;
				end
			end
			ST_SCL_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SCALE;
				state_d     = ST_SCL_FIN;
			end
			ST_SCL_FIN: begin
				cmd.scale_fin = 1'b1;
				state_d       = ST_CMP;
			end
			ST_CMP: begin
				if (sts.below) begin
					cmd.flag = 1'b1;
					state_d  = ST_DONE;
				end else begin
					state_d = ST_SQ_MUL;
				end
			end
			ST_SQ_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SQUARE;
				state_d     = ST_SQ_FIN;
			end
			ST_SQ_FIN: begin
				cmd.sq_fin = 1'b1;
				cnt_d      = '0;
				state_d    = ST_MAC_MUL;
			end
			ST_MAC_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = mac_sel(cnt_q[2:0]);
				state_d     = ST_MAC_ADD;
			end
			ST_MAC_ADD: begin
				cmd.acc_add = 1'b1;
				cmd.mul_sel = mac_sel(cnt_q[2:0]);
				if (cnt_q == CNT_W'(MAC_STEPS - 1)) begin
					state_d = ST_MS_UPD;
				end else begin
					cnt_d   = cnt_q + 1'b1;
					state_d = ST_MAC_MUL;
				end
			end
			ST_MS_UPD: begin
				cmd.ms_upd = 1'b1;
				cnt_d      = '0;
				state_d    = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// wait until the output register is free
				if (out_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/zvrs_datapath.sv =====
// -----------------------------------------------------------------------------
// zvrs_datapath
// shared 17x16 multiplier, 64-bit accumulator, mean square and sqrt unit
// -----------------------------------------------------------------------------
module zvrs_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  zvrs_pkg::cfg_t               regs,
	input  logic [zvrs_pkg::ADC_W-1:0]   adc_mv,
	input  zvrs_pkg::dp_cmd_t            cmd,
	output zvrs_pkg::dp_sts_t            sts,
	output logic [zvrs_pkg::MV_W-1:0]    rms_mv,
	output logic                         not_zener
);
	import zvrs_pkg::*;

	logic [ADC_W-1:0]  x_q;
	logic [PROD_W-1:0] prod_q;
	logic [MV_W-1:0]   scaled_q;
	logic [SQ_W-1:0]   sq_q;
	logic [ACC_W-1:0]  acc_q;
	logic [MS_W-1:0]   ms_q;
	logic [SQ_W-1:0]   rad_q;
	logic [16:0]       rem_q;
	logic [MV_W-1:0]   root_q;
	logic              nz_q;
	logic [MV_W-1:0]   rms_q;
	logic              nzo_q;

	logic [16:0]       weight;
	logic [16:0]       mul_a;
	logic [15:0]       mul_b;
	logic [ACC_W-1:0]  addend;
	logic [33:0]       rounded;
	logic [18:0]       rem_sh;
	logic [18:0]       trial;
	logic [18:0]       rem_diff;
	logic              take;

	assign weight = 17'h10000 - {1'b0, regs.alpha_q16};

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_SCALE:  begin mul_a = {4'b0, x_q};              mul_b = regs.scale_q12; end
			MUL_SQUARE: begin mul_a = {1'b0, scaled_q};         mul_b = scaled_q;       end
			MUL_MS0:    begin mul_a = weight;                   mul_b = ms_q[15:0];     end
			MUL_MS1:    begin mul_a = weight;                   mul_b = ms_q[31:16];    end
			MUL_MS2:    begin mul_a = weight;                   mul_b = ms_q[47:32];    end
			MUL_SQ0:    begin mul_a = {1'b0, regs.alpha_q16};   mul_b = sq_q[15:0];     end
			MUL_SQ1:    begin mul_a = {1'b0, regs.alpha_q16};   mul_b = sq_q[31:16];    end
			default:    begin mul_a = '0;                       mul_b = '0;             end
		endcase
	end

	// place each partial product at its weight, sum kept modulo 2^64
	always_comb begin
		unique case (cmd.mul_sel)
			MUL_MS0:          addend = {31'b0, prod_q};
			MUL_MS1, MUL_SQ0: addend = {15'b0, prod_q, 16'b0};
			MUL_MS2, MUL_SQ1: addend = {prod_q[31:0], 32'b0};
			default:          addend = '0;
		endcase
	end

	assign rounded = {1'b0, prod_q} + 34'(1 << (SCALE_FRAC_BITS - 1));

	// one root bit per step
	assign rem_sh   = {rem_q, rad_q[31:30]};
	assign trial    = {1'b0, root_q, 2'b01};
	assign take     = (rem_sh >= trial);
	assign rem_diff = rem_sh - trial;

	assign sts.below = (scaled_q < regs.min_zener_mv);
	assign rms_mv    = rms_q;
	assign not_zener = nzo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q <= '0;
		end else if (cmd.ms_upd) begin
			ms_q <= acc_q[ACC_W-1:16];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q   <= (adc_mv > regs.clamp_mv) ? regs.clamp_mv : adc_mv;
			acc_q <= 64'd32768;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + addend;
		end
		if (cmd.mul_en) begin
			prod_q <= PROD_W'(mul_a * mul_b);
		end
		if (cmd.scale_fin) begin
			scaled_q <= (rounded[33:SCALE_FRAC_BITS+16] != '0) ? '1 :
				rounded[SCALE_FRAC_BITS+15:SCALE_FRAC_BITS];
		end
		if (cmd.sq_fin) begin
			sq_q <= prod_q[SQ_W-1:0];
		end
		if (cmd.flag) begin
			root_q <= '0;
			nz_q   <= 1'b1;
		end else if (cmd.ms_upd) begin
			rad_q  <= acc_q[ACC_W-1:32];
			rem_q  <= '0;
			root_q <= '0;
			nz_q   <= 1'b0;
		end else if (cmd.sqrt_step) begin
			rad_q  <= {rad_q[29:0], 2'b00};
			rem_q  <= take ? rem_diff[16:0] : rem_sh[16:0];
			root_q <= {root_q[14:0], take};
		end
		if (cmd.publish) begin
			rms_q <= root_q;
			nzo_q <= nz_q;
		end
	end

endmodule

// ===== hw/rtl/zener_voltage_rms_smoother_unit.sv =====
// -----------------------------------------------------------------------------
// zener_voltage_rms_smoother_unit
// clamped, scaled zener reading folded into an exponential mean square, rms out
// -----------------------------------------------------------------------------
// One item in, one item out. A reading is processed one at a time. One shared
// 17x16 multiplier forms the scale product and, when the scaled voltage
// reaches the threshold, the square and the five partial products of the mean
// square update with a 64-bit accumulate after each, followed by a 16-step
// bitwise square root; a reading flagged as not a zener ends after the
// threshold compare. A finished result waits in the output register while the
// next reading is accepted. Configuration writes are taken at any time, one
// per cycle.
module zener_voltage_rms_smoother_unit (
	input  logic      clk,
	input  logic      arst_n,
	zvrs_in_if.sink   in_ch,
	zvrs_out_if.source out_ch,
	zvrs_cfg_if.sink  cfg
);
	import zvrs_pkg::*;

	`include "zener_voltage_rms_smoother_unit_defines.svh"

	cfg_t    regs;
	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	zvrs_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	zvrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (dp_cmd),
		.sts       (dp_sts)
	);

	zvrs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.adc_mv    (in_ch.adc_mv),
		.cmd       (dp_cmd),
		.sts       (dp_sts),
		.rms_mv    (out_ch.rms_mv),
		.not_zener (out_ch.not_zener)
	);

	// a new result never overwrites one still waiting
	`ZVRS_ASSERT_IMPL(a_publish_free, dp_cmd.publish, !out_ch.valid || out_ch.ready)
	// busy with one reading at a time
	`ZVRS_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
	// flagged readings carry a zero rms
	`ZVRS_ASSERT_IMPL(a_flag_zero, out_ch.valid && out_ch.not_zener, out_ch.rms_mv == 16'd0)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rms smoother testbench
// Feeds adc readings and register writes into the smoother. A fixed-point
// model of the clamp, gain, threshold and mean square update predicts each
// result. Every result is checked in order against that prediction.
// -----------------------------------------------------------------------------
module testbench;
	import zvrs_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 40;
	localparam int RAND_PHASES   = 9;
	localparam int PHASE_ITEMS   = 150;

	typedef struct packed {
		logic [MV_W-1:0] rms_mv;
		logic            not_zener;
	} rms_item_t;

	logic clk;
	logic arst_n;

	zvrs_in_if  in_ch();
	zvrs_out_if out_ch();
	zvrs_cfg_if cfg_ch();

	zener_voltage_rms_smoother_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	// predictor copy of the registers and the running mean square
	logic [ADC_W-1:0] lim_mv;
	logic [CFG_W-1:0] gain_q12;
	logic [CFG_W-1:0] thresh_mv;
	logic [CFG_W-1:0] weight_q16;
	logic [MS_W-1:0]  ms_acc;

	rms_item_t rms_expected[$];

	int errors        = 0;
	int cycles        = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left     = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// clamp, scale, threshold, then fold the square into the mean square
	function automatic rms_item_t smooth_reading(input logic [ADC_W-1:0] adc);
		logic [63:0] reading;
		logic [63:0] scaled;
		logic [63:0] target;
		logic [63:0] acc;
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] bitv;
		rms_item_t   res;
		reading = (adc > lim_mv) ? 64'(lim_mv) : 64'(adc);
		scaled = (reading * 64'(gain_q12) + 64'(1 << (SCALE_FRAC_BITS - 1))) >> SCALE_FRAC_BITS;
		if (scaled > 64'd65535)
			scaled = 64'd65535;
		if (scaled < 64'(thresh_mv)) begin
			res.rms_mv    = '0;
			res.not_zener = 1'b1;
			return res;
		end
		target = (scaled * scaled) << 16;
		acc = (64'd65536 - 64'(weight_q16)) * 64'(ms_acc) + 64'(weight_q16) * target
			+ 64'd32768;
		ms_acc = acc[63:16];
		// bitwise square root of the mean square in whole mV^2
		rem  = 64'(ms_acc) >> 16;
		root = '0;
		bitv = 64'd1 << 62;
		while (bitv > rem)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem  = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		res.rms_mv    = root[MV_W-1:0];
		res.not_zener = 1'b0;
		return res;
	endfunction

	// one process sees register writes, accepted readings and results in order
	always @(posedge clk) begin
		rms_item_t want;
		rms_item_t got;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_CLAMP: lim_mv = cfg_ch.data[ADC_W-1:0];
					REG_SCALE: gain_q12 = cfg_ch.data;
					REG_MINZ:  thresh_mv = cfg_ch.data;
					REG_ALPHA: weight_q16 = cfg_ch.data;
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				rms_expected.push_back(smooth_reading(in_ch.adc_mv));
			if (out_ch.valid && out_ch.ready) begin
				got.rms_mv    = out_ch.rms_mv;
				got.not_zener = out_ch.not_zener;
				if (rms_expected.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, actual rms_mv %0d not_zener %0b",
						$time, got.rms_mv, got.not_zener);
				end else begin
					want = rms_expected.pop_front();
					if (got.rms_mv !== want.rms_mv) begin
						errors++;
						$display("%0t: rms_mv expected %0d actual %0d",
							$time, want.rms_mv, got.rms_mv);
					end
					if (got.not_zener !== want.not_zener) begin
						errors++;
						$display("%0t: not_zener expected %0b actual %0b",
							$time, want.not_zener, got.not_zener);
					end
				end
			end
		end
	end

	// result side: random stalls, or a long hold-off when asked
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// sender idles cycle by cycle before offering the item
	task automatic send_reading(input logic [ADC_W-1:0] adc);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.adc_mv <= adc;
		do
			@(posedge clk);
		while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic write_settings(input logic [ADC_W-1:0] clamp, input logic [CFG_W-1:0] gain,
			input logic [CFG_W-1:0] thresh, input logic [CFG_W-1:0] weight);
		logic [IDX_W-1:0] codes[4];
		logic [CFG_W-1:0] vals[4];
		codes = '{REG_CLAMP, REG_SCALE, REG_MINZ, REG_ALPHA};
		vals  = '{CFG_W'(clamp), gain, thresh, weight};
		for (int i = 0; i < 4; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= codes[i];
			cfg_ch.data  <= vals[i];
			do
				@(posedge clk);
			while (!cfg_ch.ready);
			@(negedge clk);
		end
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// sender stops until every result is back, then lets the block settle
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (rms_expected.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// reset settings: zero, either side of the threshold, the clamp and the top code
	task automatic test_reset_values();
		send_reading(13'd0);
		send_reading(13'd80);
		send_reading(13'd90);
		send_reading(13'd91);
		send_reading(13'd4950);
		send_reading(13'd4951);
		send_reading(13'd5000);
		send_reading(13'd8191);
		wait_drained();
	endtask

	// largest gain with saturation, heaviest weight, threshold at the top
	task automatic test_extremes();
		write_settings(13'd8191, 16'd65535, 16'd0, 16'd65535);
		send_reading(13'd8191);
		send_reading(13'd0);
		send_reading(13'd4096);
		wait_drained();
		write_settings(13'd8191, 16'd65535, 16'd65535, 16'd1);
		send_reading(13'd4096);
		send_reading(13'd4095);
		send_reading(13'd8191);
		wait_drained();
	endtask

	// zero weight holds the mean square, zero threshold flags nothing, zero gain
	task automatic test_special_cases();
		write_settings(13'd8191, 16'd30000, 16'd100, 16'd0);
		send_reading(13'd1234);
		send_reading(13'd8191);
		wait_drained();
		write_settings(13'd0, 16'd0, 16'd65535, 16'd1);
		send_reading(13'd8191);
		wait_drained();
		write_settings(13'd0, 16'd0, 16'd0, 16'd1);
		send_reading(13'd8191);
		wait_drained();
	endtask

	// results held back long enough that the block stalls its input
	task automatic test_backpressure();
		write_settings(CLAMP_RST, SCALE_RST, MINZ_RST, ALPHA_RST);
		@(posedge clk);
		hold_left = 300;
		@(negedge clk);
		for (int i = 0; i < 6; i++)
			send_reading(ADC_W'($urandom_range(0, 5000)));
		wait_drained();
	endtask

	task automatic test_random();
		logic [ADC_W-1:0] clamp;
		logic [CFG_W-1:0] gain;
		logic [CFG_W-1:0] thresh;
		logic [CFG_W-1:0] weight;
		int               near;
		int               pick;
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p * 3 / RAND_PHASES)
				0: begin
					send_idle_pct = 18;
					recv_idle_pct = 50;
				end
				1: begin
					send_idle_pct = 50;
					recv_idle_pct = 18;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			pick = $urandom_range(3);
			clamp = (pick == 0) ? ADC_W'($urandom_range(0, 8191)) :
				(pick == 1) ? 13'd5000 : ADC_W'($urandom_range(1000, 5000));
			gain = ($urandom_range(3) == 0) ? CFG_W'($urandom_range(0, 65535)) :
				CFG_W'($urandom_range(16000, 30000));
			pick = $urandom_range(3);
			thresh = (pick == 0) ? 16'd0 :
				(pick == 1) ? CFG_W'($urandom_range(0, 65535)) : CFG_W'($urandom_range(0, 2000));
			pick = $urandom_range(3);
			weight = (pick == 0) ? 16'd65535 :
				(pick == 1) ? CFG_W'($urandom_range(1, 255)) : CFG_W'($urandom_range(1, 65535));
			write_settings(clamp, gain, thresh, weight);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick = $urandom_range(9);
				if (pick == 0 || gain == 0) begin
					near = $urandom_range(0, 8191);
				end else if (pick <= 2) begin
					// readings that land right around the threshold
					near = (int'(thresh) * 4096) / int'(gain) - 3 + int'($urandom_range(0, 6));
					if (near < 0)
						near = 0;
					if (near > 8191)
						near = 8191;
				end else begin
					near = $urandom_range(0, 5000);
				end
				send_reading(ADC_W'(near));
			end
			wait_drained();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.adc_mv  = '0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = REG_CLAMP;
		cfg_ch.data   = '0;
		out_ch.ready  = 1'b0;
		lim_mv        = CLAMP_RST;
		gain_q12      = SCALE_RST;
		thresh_mv     = MINZ_RST;
		weight_q16    = ALPHA_RST;
		ms_acc        = '0;
		send_idle_pct = 18;
		recv_idle_pct = 50;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_values();
		test_extremes();
		test_special_cases();
		test_backpressure();
		test_random();

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
